/* src/pclt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pclt_pkg: shared types and codes for the connection limit table
// Transfer structs for requests and responses, status and command codes,
// and the default table geometry.
// ----------------------------------------------------------------------------
package pclt_pkg;

   // fixed field widths
   localparam int ADDR_W   = 32;
   localparam int LIMIT_W  = 16;
   localparam int RCOUNT_W = 16;
   localparam int STATUS_W = 3;

   // default geometry
   localparam int DEF_NUM_SETS   = 16;
   localparam int DEF_NUM_WAYS   = 8;
   localparam int DEF_COUNT_BITS = 16;

   // the set is picked from the low four bits of the byte sum
   localparam logic [3:0] SET_MASK = 4'hf;

   // commands
   localparam logic CMD_OPEN  = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_LIMIT     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_SET_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_DISABLED  = 3'd4;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] ip_addr;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [STATUS_W-1:0] status;
      logic [RCOUNT_W-1:0] conn_count;
   } rsp_type;

endpackage
`default_nettype wire

/* src/pclt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pclt_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pclt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* src/per_source_connection_limit_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_connection_limit_table: live connection counts per IPv4 source
// Set-associative table of addresses and counts; grants or refuses connect
// and disconnect events against a programmable per-address limit.
// ----------------------------------------------------------------------------
// In the accept cycle of an event the set row is read from the row
// memories (address and count row, valid row), and in the next cycle all
// ways are searched and the row is updated and written back where the
// event changes it. The result appears on rsp for exactly one cycle,
// flagged by rsp_valid, in the cycle after that; the receiver cannot stall
// it, and a new event may be accepted in that same cycle, but not while the
// last one is in its lookup. After reset, busy stays high while the valid
// memory is cleared one set row per cycle; csr writes are taken throughout.
// ----------------------------------------------------------------------------
module per_source_connection_limit_table #(
   parameter int NUM_SETS   = pclt_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS   = pclt_pkg::DEF_NUM_WAYS,
   parameter int COUNT_BITS = pclt_pkg::DEF_COUNT_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire pclt_pkg::req_type              req,
   output logic                                rsp_valid,
   output pclt_pkg::rsp_type                   rsp,
   input  wire logic                           csr_we,
   input  wire logic [pclt_pkg::LIMIT_W-1:0]   csr_wdata
);

   import pclt_pkg::*;

   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int ENT_W = ADDR_W + COUNT_BITS;
   localparam int ROW_W = NUM_WAYS * ENT_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [SET_W-1:0]      LAST_SET  = SET_W'(NUM_SETS - 1);
   localparam logic [7:0]            LAST_SET8 = 8'(NUM_SETS - 1);

   // sequencer states
   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_LOOKUP = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [SET_W-1:0]    clear_ptr_ff, clear_ptr_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic                cmd_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [SET_W-1:0]    set_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic [9:0]          byte_sum;
   logic [7:0]          set8;
   logic [SET_W-1:0]    req_set;

   logic [ROW_W-1:0]    data_row;
   logic [NUM_WAYS-1:0] valid_row;
   logic [ROW_W-1:0]    data_row_in;
   logic [NUM_WAYS-1:0] valid_row_in;
   logic                tbl_we;
   logic                valid_we;
   logic [SET_W-1:0]    valid_wr_addr;
   logic [NUM_WAYS-1:0] valid_wr_data;

   logic                found;
   logic                have_free;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    free_way;
   logic [COUNT_BITS-1:0] hit_count;
   logic [COUNT_BITS-1:0] inc_count;
   logic [COUNT_BITS-1:0] dec_count;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // set pick: low four bits of the byte sum, clamped to the last set
   always_comb begin
      byte_sum = 10'(req.ip_addr[7:0]) + 10'(req.ip_addr[15:8])
               + 10'(req.ip_addr[23:16]) + 10'(req.ip_addr[31:24]);
      set8 = {4'b0, byte_sum[3:0] & SET_MASK};
      if (32'(set8) >= 32'(NUM_SETS)) begin
         set8 = LAST_SET8;
      end
      req_set = set8[SET_W-1:0];
   end

   // row memories: address/count row and valid row
   pclt_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_data_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (set_ff),
      .wr_data (data_row_in),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (data_row)
   );

   pclt_ram #(.WIDTH(NUM_WAYS), .DEPTH(NUM_SETS)) u_valid_ram (
      .clock   (clock),
      .wr_en   (valid_we),
      .wr_addr (valid_wr_addr),
      .wr_data (valid_wr_data),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (valid_row)
   );

   // valid memory write: clearing sweep after reset, else the lookup update
   always_comb begin
      if (state_ff == S_CLEAR) begin
         valid_we      = 1'b1;
         valid_wr_addr = clear_ptr_ff;
         valid_wr_data = '0;
      end else begin
         valid_we      = tbl_we;
         valid_wr_addr = set_ff;
         valid_wr_data = valid_row_in;
      end
   end

   // way search: first matching valid way, first free way
   always_comb begin
      found     = 1'b0;
      have_free = 1'b0;
      hit_way   = '0;
      free_way  = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (valid_row[w]) begin
            if (data_row[w*ENT_W+COUNT_BITS +: ADDR_W] == addr_ff) begin
               found   = 1'b1;
               hit_way = WAY_W'(w);
            end
         end else begin
            have_free = 1'b1;
            free_way  = WAY_W'(w);
         end
      end
   end

   assign hit_count = data_row[32'(hit_way)*ENT_W +: COUNT_BITS];
   assign inc_count = hit_count + COUNT_ONE;
   assign dec_count = hit_count - COUNT_ONE;

   // decision and row update
   always_comb begin
      data_row_in  = data_row;
      valid_row_in = valid_row;
      tbl_we       = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      if (state_ff == S_LOOKUP) begin
         rsp_valid_in = 1'b1;
         if (limit_ff == '0) begin
            rsp_in = '{granted: 1'b1, status: STAT_DISABLED, conn_count: '0};
         end else if (cmd_ff == CMD_OPEN) begin
            if (found) begin
               if ((32'(hit_count) < 32'(limit_ff)) && (hit_count != COUNT_MAX)) begin
                  tbl_we = 1'b1;
                  data_row_in[32'(hit_way)*ENT_W +: COUNT_BITS] = inc_count;
                  rsp_in = '{granted: 1'b1, status: STAT_OK,
                             conn_count: RCOUNT_W'(inc_count)};
               end else begin
                  rsp_in = '{granted: 1'b0, status: STAT_LIMIT,
                             conn_count: RCOUNT_W'(hit_count)};
               end
            end else if (have_free) begin
               tbl_we = 1'b1;
               valid_row_in[free_way] = 1'b1;
               data_row_in[32'(free_way)*ENT_W +: ENT_W] = {addr_ff, COUNT_ONE};
               rsp_in = '{granted: 1'b1, status: STAT_OK, conn_count: RCOUNT_W'(1)};
            end else begin
               rsp_in = '{granted: 1'b0, status: STAT_SET_FULL, conn_count: '0};
            end
         end else begin
            if (found) begin
               tbl_we = 1'b1;
               if (hit_count > COUNT_ONE) begin
                  data_row_in[32'(hit_way)*ENT_W +: COUNT_BITS] = dec_count;
                  rsp_in = '{granted: 1'b1, status: STAT_OK,
                             conn_count: RCOUNT_W'(dec_count)};
               end else begin
                  valid_row_in[hit_way] = 1'b0;
                  rsp_in = '{granted: 1'b1, status: STAT_OK, conn_count: '0};
               end
            end else begin
               rsp_in = '{granted: 1'b0, status: STAT_NOT_FOUND, conn_count: '0};
            end
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clear_ptr_in = clear_ptr_ff;
      case (state_ff)
         S_CLEAR: begin
            clear_ptr_in = clear_ptr_ff + SET_W'(1);
            if (clear_ptr_ff == LAST_SET) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clear_ptr_ff <= clear_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req.cmd;
         addr_ff <= req.ip_addr;
         set_ff  <= req_set;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   // an accepted event is looked up in the following cycle
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOKUP))
      else $error("accepted event not followed by lookup");

   // every lookup yields exactly one response strobe
   a_lookup_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP) |=> rsp_valid)
      else $error("lookup without response");

   // a response only shows once the block is ready again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_IDLE) && $past(state_ff == S_LOOKUP))
      else $error("response outside lookup sequence");

   // a refusal always carries a refusal status
   a_refuse_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.granted) |-> (rsp.status == STAT_LIMIT ||
         rsp.status == STAT_NOT_FOUND || rsp.status == STAT_SET_FULL))
      else $error("refused event with grant status");

   // bypass responses carry no count
   a_disabled_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == STAT_DISABLED) |-> rsp.granted && (rsp.conn_count == '0))
      else $error("bad bypass response");
`endif

endmodule
`default_nettype wire

/* sim/per_source_connection_limit_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_connection_limit_table_test: self-checking bench for the limiter
// Drives connect and disconnect events, tracks the expected table contents in
// a behavioral copy of the set-associative table, and checks every response
// field by field. Covers limiting disabled, limit reached, high counts,
// set full, unknown address on close, and limit changes over live entries.
// ----------------------------------------------------------------------------
module per_source_connection_limit_table_test;
   import pclt_pkg::*;

   localparam int NUM_SETS    = DEF_NUM_SETS;
   localparam int NUM_WAYS    = DEF_NUM_WAYS;
   localparam int COUNT_BITS  = DEF_COUNT_BITS;
   localparam int TABLE_DEPTH = NUM_SETS * NUM_WAYS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_GAP   = 4;
   localparam int DEEP_OPENS  = 12;

   // clock, reset and DUT ports
   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req = '0;
   logic                rsp_valid;
   rsp_type             rsp;
   logic                csr_we = 1'b0;
   logic [LIMIT_W-1:0]  csr_wdata = '0;

   // expected table contents and the limit as the block sees it
   logic [ADDR_W-1:0]     tbl_addr  [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] tbl_count [TABLE_DEPTH];
   logic                  tbl_valid [TABLE_DEPTH] = '{default: 1'b0};
   logic [LIMIT_W-1:0]    conn_limit = '0;

   // events waiting to go out, and verdicts waiting to come back
   req_type queued_events[$];
   rsp_type pending_verdicts[$];

   int   in_flight   = 0;
   int   sent_count  = 0;
   int   idle_pct    = 0;
   int   idle_cycles = 0;
   int   error_count = 0;
   logic req_taken   = 1'b0;
   logic drain_hold  = 1'b0;

   per_source_connection_limit_table uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // apply one event to the expected table and return the verdict
   function automatic rsp_type predict_verdict(input req_type ev);
      rsp_type    v;
      logic [9:0] byte_sum;
      int         set_idx;
      int         base;
      int         way;
      int         hit_idx;
      int         free_idx;
      v = '0;
      if (conn_limit == '0) begin
         v.granted = 1'b1;
         v.status  = STAT_DISABLED;
         return v;
      end
      byte_sum = 10'(ev.ip_addr[7:0]) + 10'(ev.ip_addr[15:8])
               + 10'(ev.ip_addr[23:16]) + 10'(ev.ip_addr[31:24]);
      set_idx  = int'(byte_sum[3:0] & SET_MASK);
      if (set_idx >= NUM_SETS) set_idx = NUM_SETS - 1;
      base     = set_idx * NUM_WAYS;
      hit_idx  = -1;
      free_idx = -1;
      for (way = 0; way < NUM_WAYS; way++) begin
         if (tbl_valid[base+way]) begin
            if (hit_idx < 0 && tbl_addr[base+way] == ev.ip_addr) hit_idx = base + way;
         end else if (free_idx < 0) begin
            free_idx = base + way;
         end
      end
      if (ev.cmd == CMD_OPEN) begin
         if (hit_idx >= 0) begin
            if (tbl_count[hit_idx] < conn_limit && tbl_count[hit_idx] < COUNT_MAX) begin
               tbl_count[hit_idx] = tbl_count[hit_idx] + 1'b1;
               v.granted = 1'b1;
               v.status  = STAT_OK;
            end else begin
               v.status = STAT_LIMIT;
            end
            v.conn_count = RCOUNT_W'(tbl_count[hit_idx]);
         end else if (free_idx >= 0) begin
            tbl_valid[free_idx] = 1'b1;
            tbl_addr[free_idx]  = ev.ip_addr;
            tbl_count[free_idx] = COUNT_BITS'(1);
            v.granted    = 1'b1;
            v.status     = STAT_OK;
            v.conn_count = RCOUNT_W'(1);
         end else begin
            v.status = STAT_SET_FULL;
         end
      end else begin
         if (hit_idx >= 0) begin
            v.granted = 1'b1;
            v.status  = STAT_OK;
            if (tbl_count[hit_idx] > 1) begin
               tbl_count[hit_idx] = tbl_count[hit_idx] - 1'b1;
               v.conn_count = RCOUNT_W'(tbl_count[hit_idx]);
            end else begin
               tbl_valid[hit_idx] = 1'b0;
            end
         end else begin
            v.status = STAT_NOT_FOUND;
         end
      end
      return v;
   endfunction

   // address whose byte sum lands in the given set
   function automatic logic [31:0] addr_in_set(input int set_idx, input logic [23:0] upper);
      logic [9:0] part;
      logic [7:0] low;
      part = 10'(upper[7:0]) + 10'(upper[15:8]) + 10'(upper[23:16]);
      low  = {4'($urandom_range(15)), 4'(set_idx - int'(part))};
      return {upper, low};
   endfunction

   task automatic add_event(input logic c, input logic [31:0] a);
      queued_events.push_back('{cmd: c, ip_addr: a});
   endtask

   // block until every queued event has its verdict, then let the pipe settle
   task automatic wait_drained();
      while (queued_events.size() != 0 || in_flight != 0) @(negedge clock);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // random traffic concentrated on a few sets so hits, limits and full sets occur
   task automatic add_random_phase(input int n);
      int          hot_set[3];
      logic [31:0] pool[$];
      logic [31:0] a;
      int          k;
      for (k = 0; k < 3; k++) hot_set[k] = $urandom_range(NUM_SETS - 1);
      for (k = 0; k < 20; k++) pool.push_back(addr_in_set(hot_set[k % 3], 24'($urandom)));
      for (k = 0; k < n; k++) begin
         a = ($urandom_range(99) < 88) ? pool[$urandom_range(pool.size() - 1)] : $urandom();
         add_event(($urandom_range(99) < 55) ? CMD_OPEN : CMD_CLOSE, a);
      end
   endtask

   // driver: offers the next event at the falling edge once the last one is taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (drain_hold && in_flight == 0) drain_hold = 1'b0;
         if (drain_hold || queued_events.size() == 0 || $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
         end else begin
            req   <= queued_events.pop_front();
            start <= 1'b1;
            in_flight++;
            sent_count++;
            // now and then hold off until everything outstanding has come back
            if (sent_count % 97 == 0) drain_hold = 1'b1;
         end
      end
   end

   // monitor: checks verdicts, predicts on each transfer, tracks the limit
   always @(posedge clock) begin : monitor
      rsp_type exp_rsp;
      req_taken = !reset && start && !busy;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $error("response with no event outstanding");
            error_count++;
         end else begin
            exp_rsp = pending_verdicts.pop_front();
            in_flight--;
            if (rsp.granted !== exp_rsp.granted) begin
               $error("granted: expected %0d, got %0d", exp_rsp.granted, rsp.granted);
               error_count++;
            end
            if (rsp.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
               error_count++;
            end
            if (rsp.conn_count !== exp_rsp.conn_count) begin
               $error("conn_count: expected %0d, got %0d", exp_rsp.conn_count, rsp.conn_count);
               error_count++;
            end
         end
      end
      if (req_taken) pending_verdicts.push_back(predict_verdict(req));
      if (!reset && csr_we) conn_limit = csr_wdata;
      if (req_taken || (!reset && rsp_valid === 1'b1) || csr_we) idle_cycles = 0;
      else idle_cycles++;
   end

   // watchdog on cycles without any transfer
   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // stimulus sequence
   initial begin : stimulus
      logic [31:0] set5_addr[9];
      logic [31:0] deep_addr;
      int          k;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // limiting disabled out of reset: both commands pass untouched
      add_event(CMD_OPEN, 32'h0000_0000);
      add_event(CMD_CLOSE, 32'hffff_ffff);
      wait_drained();

      // count up to the limit, refuse, count down, free, then close unknown
      write_limit(16'd2);
      add_event(CMD_OPEN, 32'h0000_0000);
      add_event(CMD_OPEN, 32'h0000_0000);
      add_event(CMD_OPEN, 32'h0000_0000);
      add_event(CMD_CLOSE, 32'h0000_0000);
      add_event(CMD_CLOSE, 32'h0000_0000);
      add_event(CMD_CLOSE, 32'h0000_0000);
      add_event(CMD_OPEN, 32'hffff_ffff);
      add_event(CMD_CLOSE, 32'hffff_ffff);
      // fill one set, overflow it, free a way and insert into it
      for (k = 0; k < 9; k++) begin
         set5_addr[k] = addr_in_set(5, {8'(k + 8'h40), 16'($urandom)});
         add_event(CMD_OPEN, set5_addr[k]);
      end
      add_event(CMD_CLOSE, set5_addr[2]);
      add_event(CMD_OPEN, set5_addr[8]);
      add_event(CMD_OPEN, 32'h8080_8080);
      wait_drained();

      // build up a deep count on one entry under the widest limit
      write_limit(16'hffff);
      deep_addr = addr_in_set(9, 24'hc3a55a);
      for (k = 0; k < DEEP_OPENS; k++) add_event(CMD_OPEN, deep_addr);
      add_event(CMD_CLOSE, deep_addr);
      add_event(CMD_CLOSE, deep_addr);
      wait_drained();

      // limit dropped under a live count: opens refused, closes still work
      write_limit(16'd1);
      add_event(CMD_OPEN, deep_addr);
      add_event(CMD_CLOSE, deep_addr);
      wait_drained();

      // random phases over several limits and idle rates
      write_limit(16'd3);
      idle_pct = 0;
      add_random_phase(150);
      wait_drained();

      write_limit(16'd1);
      idle_pct = 51;
      add_random_phase(150);
      wait_drained();

      write_limit(16'hffff);
      idle_pct = 21;
      add_random_phase(150);
      wait_drained();

      write_limit(16'd0);
      idle_pct = 0;
      add_random_phase(80);
      wait_drained();

      write_limit(16'd2);
      idle_pct = 51;
      add_random_phase(150);
      wait_drained();

      write_limit(16'd7);
      idle_pct = 21;
      add_random_phase(150);
      wait_drained();

      write_limit(16'd4);
      idle_pct = 0;
      add_random_phase(100);
      wait_drained();
      repeat (8) @(negedge clock);

      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
src/pclt_pkg.sv
src/pclt_ram.sv
src/per_source_connection_limit_table.sv
sim/per_source_connection_limit_table_test.sv
